/* design/dagel_pkg.sv */
// Shared constants, codes and command/status types of the DAG earliest-level block.
package dagel_pkg;

    localparam int NODE_W      = 6;
    localparam int LEVEL_W     = 6;
    localparam int CFG_W       = 7;
    localparam int NODE_LIMIT  = 2 ** NODE_W;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    localparam logic [CFG_W-1:0]   CFG_RESET = 7'd64;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd63;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    typedef struct packed {
        logic load;
        logic init;
        logic clr;
        logic edge_rd;
        logic deg_rd;
        logic cnt_wr;
        logic seed_rd;
        logic seed_chk;
        logic pop;
        logic lvl_rd;
        logic scan_wr;
        logic out_rd;
        logic out_em;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic e_end;
        logic edge_in;
        logic scan_hit;
        logic node_last;
        logic q_empty;
    } t_sts;

endpackage

/* design/dagel_ctrl.sv */
// Controller state machine that sequences edge loads and the level walk.
module dagel_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_opcode,
    input  dagel_pkg::t_sts  i_sts,
    output dagel_pkg::t_cmd  o_cmd,
    output logic             o_busy
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_CLR      = 14'h0002,
        S_CNT_RD   = 14'h0004,
        S_CNT_DEG  = 14'h0008,
        S_CNT_WR   = 14'h0010,
        S_SEED_RD  = 14'h0020,
        S_SEED_CHK = 14'h0040,
        S_POP      = 14'h0080,
        S_POP_LVL  = 14'h0100,
        S_SCAN_RD  = 14'h0200,
        S_SCAN_CHK = 14'h0400,
        S_SCAN_WR  = 14'h0800,
        S_OUT_RD   = 14'h1000,
        S_OUT_EM   = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == dagel_pkg::OP_RUN) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_CLR;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                if (i_sts.e_end) begin
                    n_state = S_SEED_RD;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_CNT_DEG;
                end
            end
            S_CNT_DEG: begin
                if (i_sts.edge_in) begin
                    o_cmd.deg_rd = 1'b1;
                    n_state      = S_CNT_WR;
                end else begin
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_CNT_RD;
            end
            S_SEED_RD: begin
                o_cmd.seed_rd = 1'b1;
                n_state       = S_SEED_CHK;
            end
            S_SEED_CHK: begin
                o_cmd.seed_chk = 1'b1;
                n_state        = i_sts.node_last ? S_POP : S_SEED_RD;
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP_LVL;
                end
            end
            S_POP_LVL: begin
                o_cmd.lvl_rd = 1'b1;
                n_state      = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.e_end) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.scan_hit) begin
                    o_cmd.deg_rd = 1'b1;
                    n_state      = S_SCAN_WR;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_WR: begin
                o_cmd.scan_wr = 1'b1;
                n_state       = S_SCAN_RD;
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OUT_EM;
            end
            S_OUT_EM: begin
                o_cmd.out_em = 1'b1;
                n_state      = i_sts.node_last ? S_IDLE : S_OUT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* design/dagel_dp.sv */
// Datapath: edge store, in-degree, level and ready-queue memories with their counters.
module dagel_dp #(
    parameter int MAX_NODES = dagel_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = dagel_pkg::MAX_EDGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dagel_pkg::CFG_W-1:0]   i_cfg_node_count,
    input  logic [dagel_pkg::NODE_W-1:0]  i_edge_source,
    input  logic [dagel_pkg::NODE_W-1:0]  i_edge_target,
    input  dagel_pkg::t_cmd               i_cmd,
    output dagel_pkg::t_sts               o_sts,
    output logic                          o_valid,
    output logic [dagel_pkg::NODE_W-1:0]  o_node_index,
    output logic [dagel_pkg::LEVEL_W-1:0] o_level,
    output logic                          o_last
);

    localparam int CW       = dagel_pkg::CFG_W;
    localparam int NW       = dagel_pkg::NODE_W;
    localparam int LW       = dagel_pkg::LEVEL_W;
    localparam int NODE_CAP = (MAX_NODES < dagel_pkg::NODE_LIMIT) ? MAX_NODES
                                                                  : dagel_pkg::NODE_LIMIT;
    localparam int NIDX_W   = $clog2(NODE_CAP);
    localparam int NC_W     = $clog2(NODE_CAP + 1);
    localparam int EA_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W     = $clog2(MAX_EDGES + 1);

    localparam logic [CW-1:0]   CAP_N     = CW'(NODE_CAP);
    localparam logic [NC_W-1:0] NCAP_LAST = NC_W'(NODE_CAP - 1);
    localparam logic [EC_W-1:0] EDGES_TOP = EC_W'(MAX_EDGES);

    logic [CW-1:0]   r_node_count;
    logic [EC_W-1:0] r_edges_held;
    logic [EC_W-1:0] r_e;
    logic [NC_W-1:0] r_v;
    logic [NC_W-1:0] r_head;
    logic [NC_W-1:0] r_tail;

    logic [NW-1:0]   m_from  [MAX_EDGES];
    logic [NW-1:0]   m_to    [MAX_EDGES];
    logic [EC_W-1:0] m_indeg [NODE_CAP];
    logic [LW-1:0]   m_lvl   [NODE_CAP];
    logic [NW-1:0]   m_queue [NODE_CAP];

    logic [NW-1:0]   r_from_q;
    logic [NW-1:0]   r_to_q;
    logic [EC_W-1:0] r_indeg_q;
    logic [LW-1:0]   r_lvl_q;
    logic [NW-1:0]   r_queue_q;

    logic [CW-1:0]     w_n;
    logic [CW-1:0]     w_n_last;
    logic              w_load_ok;
    logic              w_node_last;
    logic              w_deg_we;
    logic [NIDX_W-1:0] w_deg_waddr;
    logic [EC_W-1:0]   w_deg_wdata;
    logic [NIDX_W-1:0] w_deg_raddr;
    logic              w_hit_zero;
    logic              w_lvl_we;
    logic [NIDX_W-1:0] w_lvl_waddr;
    logic [LW-1:0]     w_lvl_wdata;
    logic [NIDX_W-1:0] w_lvl_raddr;
    logic [LW-1:0]     w_next_lvl;
    logic              w_enq;
    logic [NW-1:0]     w_enq_data;

    always_comb begin
        if (r_node_count == '0) begin
            w_n = CW'(1);
        end else if (r_node_count > CAP_N) begin
            w_n = CAP_N;
        end else begin
            w_n = r_node_count;
        end
    end

    assign w_n_last    = w_n - CW'(1);
    assign w_node_last = (CW'(r_v) == w_n_last);
    assign w_load_ok   = i_cmd.load && (CW'(i_edge_source) < w_n)
                         && (CW'(i_edge_target) < w_n) && (r_edges_held != EDGES_TOP);

    assign w_next_lvl  = (r_lvl_q == dagel_pkg::LEVEL_MAX) ? dagel_pkg::LEVEL_MAX
                                                           : r_lvl_q + LW'(1);
    assign w_hit_zero  = i_cmd.scan_wr && (r_indeg_q == EC_W'(1));

    assign w_deg_we    = i_cmd.clr || i_cmd.cnt_wr || (i_cmd.scan_wr && (r_indeg_q != '0));
    assign w_deg_waddr = i_cmd.clr ? r_v[NIDX_W-1:0] : r_to_q[NIDX_W-1:0];
    assign w_deg_wdata = i_cmd.clr ? '0
                       : i_cmd.cnt_wr ? r_indeg_q + EC_W'(1) : r_indeg_q - EC_W'(1);
    assign w_deg_raddr = i_cmd.seed_rd ? r_v[NIDX_W-1:0] : r_to_q[NIDX_W-1:0];

    assign w_lvl_we    = i_cmd.clr || w_hit_zero;
    assign w_lvl_waddr = i_cmd.clr ? r_v[NIDX_W-1:0] : r_to_q[NIDX_W-1:0];
    assign w_lvl_wdata = i_cmd.clr ? '0 : w_next_lvl;
    assign w_lvl_raddr = i_cmd.lvl_rd ? r_queue_q[NIDX_W-1:0] : r_v[NIDX_W-1:0];

    assign w_enq       = (i_cmd.seed_chk && (r_indeg_q == '0)) || w_hit_zero;
    assign w_enq_data  = i_cmd.seed_chk ? NW'(r_v) : r_to_q;

    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            m_from[r_edges_held[EA_W-1:0]] <= i_edge_source;
            m_to[r_edges_held[EA_W-1:0]]   <= i_edge_target;
        end
        if (i_cmd.edge_rd) begin
            r_from_q <= m_from[r_e[EA_W-1:0]];
            r_to_q   <= m_to[r_e[EA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deg_we) begin
            m_indeg[w_deg_waddr] <= w_deg_wdata;
        end
        if (i_cmd.deg_rd || i_cmd.seed_rd) begin
            r_indeg_q <= m_indeg[w_deg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lvl_we) begin
            m_lvl[w_lvl_waddr] <= w_lvl_wdata;
        end
        if (i_cmd.lvl_rd || i_cmd.out_rd) begin
            r_lvl_q <= m_lvl[w_lvl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            m_queue[r_tail[NIDX_W-1:0]] <= w_enq_data;
        end
        if (i_cmd.pop) begin
            r_queue_q <= m_queue[r_head[NIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= dagel_pkg::CFG_RESET;
            r_edges_held <= '0;
            r_e          <= '0;
            r_v          <= '0;
            r_head       <= '0;
            r_tail       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_node_count;
            end
            if (i_cmd.out_em && w_node_last) begin
                r_edges_held <= '0;
            end else if (w_load_ok) begin
                r_edges_held <= r_edges_held + EC_W'(1);
            end
            if (i_cmd.init || i_cmd.pop) begin
                r_e <= '0;
            end else if (i_cmd.edge_rd) begin
                r_e <= r_e + EC_W'(1);
            end
            if (i_cmd.init) begin
                r_v <= '0;
            end else if (i_cmd.clr) begin
                r_v <= (r_v == NCAP_LAST) ? '0 : r_v + NC_W'(1);
            end else if (i_cmd.seed_chk || i_cmd.out_em) begin
                r_v <= w_node_last ? '0 : r_v + NC_W'(1);
            end
            if (i_cmd.init) begin
                r_head <= '0;
                r_tail <= '0;
            end else begin
                if (i_cmd.pop) begin
                    r_head <= r_head + NC_W'(1);
                end
                if (w_enq) begin
                    r_tail <= r_tail + NC_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_v == NCAP_LAST);
        o_sts.e_end     = (r_e == r_edges_held);
        o_sts.edge_in   = (CW'(r_from_q) < w_n) && (CW'(r_to_q) < w_n);
        o_sts.scan_hit  = (r_from_q == r_queue_q) && (CW'(r_to_q) < w_n);
        o_sts.node_last = w_node_last;
        o_sts.q_empty   = (r_head == r_tail);
    end

    assign o_valid      = i_cmd.out_em;
    assign o_node_index = NW'(r_v);
    assign o_level      = r_lvl_q;
    assign o_last       = i_cmd.out_em && w_node_last;

endmodule

/* design/dag_earliest_level_top.sv */
// Top level of the DAG earliest-level block: controller, datapath and checks.
//
// An add-edge request is taken while busy stays low, so edges load back to back.
// A run request raises busy until its last result: a clearing pass over min(MAX_NODES,64)
// entries of the in-degree and level memories, an in-degree count of each stored edge
// whose ends both lie inside the node range, a seeding pass that queues each node of
// in-degree zero, then for each queued node a level read and a scan of the edge store
// that lowers the in-degree of each target in range of an edge leaving it and queues a
// target that reaches zero, a check that finds the queue empty, and finally the results,
// node by node, each after a level read, o_last on the final one. The walk is dominated
// by the edge store, which is swept once per queued node. Results appear on o_valid for
// one cycle each and are not held back.
module dag_earliest_level_top #(
    parameter int MAX_NODES = dagel_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = dagel_pkg::MAX_EDGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dagel_pkg::CFG_W-1:0]   i_cfg_node_count,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [dagel_pkg::NODE_W-1:0]  i_edge_source,
    input  logic [dagel_pkg::NODE_W-1:0]  i_edge_target,
    output logic                          o_valid,
    output logic [dagel_pkg::NODE_W-1:0]  o_node_index,
    output logic [dagel_pkg::LEVEL_W-1:0] o_level,
    output logic                          o_last
);

    dagel_pkg::t_cmd w_cmd;
    dagel_pkg::t_sts w_sts;

    dagel_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    dagel_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_node_count (i_cfg_node_count),
        .i_edge_source    (i_edge_source),
        .i_edge_target    (i_edge_target),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .o_node_index     (o_node_index),
        .o_level          (o_level),
        .o_last           (o_last)
    );

`ifndef SYNTH
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a run");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == dagel_pkg::OP_RUN) |=> busy)
        else $error("run request did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("block still busy after last result");

    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (!o_valid && busy))
        else $error("results not spaced by the level read");
`endif

endmodule

/* dv/dag_earliest_level_checker.sv */
// Checker for the DAG earliest-level block: watches requests and results, predicts levels.
module dag_earliest_level_checker
    import dagel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_node_count,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_opcode,
    input  logic [NODE_W-1:0]  i_edge_source,
    input  logic [NODE_W-1:0]  i_edge_target,
    input  logic               i_valid,
    input  logic [NODE_W-1:0]  i_node_index,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic               i_last,
    output int                 o_mismatches,
    output int                 o_levels_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CAP = MAX_NODES_DEF < 64 ? MAX_NODES_DEF : 64;
    localparam int EDGE_CAP = MAX_EDGES_DEF;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_node_level;

    logic [CFG_W-1:0]  node_count_reg = CFG_RESET;
    logic [NODE_W-1:0] edge_from [EDGE_CAP];
    logic [NODE_W-1:0] edge_to [EDGE_CAP];
    int                edges_held = 0;
    int                mismatch_count = 0;
    t_node_level       level_q[$];

    assign o_mismatches = mismatch_count;

    function automatic int nodes_in_use();
        int n;
        n = int'(node_count_reg);
        if (n == 0) n = 1;
        if (n > NODE_CAP) n = NODE_CAP;
        return n;
    endfunction

    task automatic load_edge(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
        int n;
        n = nodes_in_use();
        if (int'(src) < n && int'(dst) < n && edges_held < EDGE_CAP) begin
            edge_from[edges_held] = src;
            edge_to[edges_held]   = dst;
            edges_held++;
        end
    endtask

    task automatic predict_levels();
        int          n;
        int          indeg [NODE_CAP];
        int          lvl [NODE_CAP];
        int          ready[$];
        int          cur;
        int          raised;
        t_node_level r;
        n = nodes_in_use();
        for (int v = 0; v < NODE_CAP; v++) begin
            indeg[v] = 0;
            lvl[v]   = 0;
        end
        for (int e = 0; e < edges_held; e++)
            if (int'(edge_from[e]) < n && int'(edge_to[e]) < n) indeg[edge_to[e]]++;
        for (int v = 0; v < n; v++)
            if (indeg[v] == 0) ready.push_back(v);
        while (ready.size() != 0) begin
            cur = ready.pop_front();
            for (int e = 0; e < edges_held; e++) begin
                if (int'(edge_from[e]) == cur && int'(edge_to[e]) < n
                    && indeg[edge_to[e]] != 0) begin
                    indeg[edge_to[e]]--;
                    if (indeg[edge_to[e]] == 0) begin
                        raised = lvl[cur] + 1;
                        lvl[edge_to[e]] = raised > int'(LEVEL_MAX) ? int'(LEVEL_MAX) : raised;
                        ready.push_back(int'(edge_to[e]));
                    end
                end
            end
        end
        for (int v = 0; v < n; v++) begin
            r.node  = NODE_W'(v);
            r.level = LEVEL_W'(lvl[v]);
            r.last  = (v == n - 1);
            level_q.push_back(r);
        end
        edges_held = 0;
    endtask

    always @(posedge i_clk) begin
        t_node_level want;
        if (!i_rst_n) begin
            node_count_reg = CFG_RESET;
            edges_held = 0;
            level_q.delete();
        end else begin
            if (i_valid) begin
                if (level_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result node %0d level %0d last %0b",
                             $time, i_node_index, i_level, i_last);
                end else begin
                    want = level_q.pop_front();
                    if (want.node !== i_node_index) begin
                        mismatch_count++;
                        $display("%0t: node_index expected %0d actual %0d",
                                 $time, want.node, i_node_index);
                    end
                    if (want.level !== i_level) begin
                        mismatch_count++;
                        $display("%0t: level of node %0d expected %0d actual %0d",
                                 $time, want.node, want.level, i_level);
                    end
                    if (want.last !== i_last) begin
                        mismatch_count++;
                        $display("%0t: last of node %0d expected %0b actual %0b",
                                 $time, want.node, want.last, i_last);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_opcode == OP_ADD) load_edge(i_edge_source, i_edge_target);
                else predict_levels();
            end
            if (i_cfg_we) node_count_reg = i_cfg_node_count;
        end
        o_levels_owed = level_q.size();
    end

endmodule

/* dv/dag_earliest_level_top_tb.sv */
// Testbench top for the DAG earliest-level block: clock, reset, request stimulus, verdict.
module dag_earliest_level_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dagel_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_node_count;
    logic               start;
    logic               busy;
    logic               opcode;
    logic [NODE_W-1:0]  edge_source;
    logic [NODE_W-1:0]  edge_target;
    logic               valid;
    logic [NODE_W-1:0]  node_index;
    logic [LEVEL_W-1:0] level;
    logic               last;
    int                 mismatches;
    int                 levels_owed;
    int                 requests_sent = 0;
    int                 chains_done = 0;
    bit                 steady = 1'b0;

    dag_earliest_level_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_node_count (cfg_node_count),
        .start            (start),
        .busy             (busy),
        .i_opcode         (opcode),
        .i_edge_source    (edge_source),
        .i_edge_target    (edge_target),
        .o_valid          (valid),
        .o_node_index     (node_index),
        .o_level          (level),
        .o_last           (last)
    );

    dag_earliest_level_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_node_count (cfg_node_count),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (opcode),
        .i_edge_source    (edge_source),
        .i_edge_target    (edge_target),
        .i_valid          (valid),
        .i_node_index     (node_index),
        .i_level          (level),
        .i_last           (last),
        .o_mismatches     (mismatches),
        .o_levels_owed    (levels_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int active_of(input int v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return v;
    endfunction

    task automatic send_request(input logic op, input int src, input int dst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        edge_source <= src[NODE_W-1:0];
        edge_target <= dst[NODE_W-1:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    task automatic add_edge(input int src, input int dst);
        send_request(OP_ADD, src, dst);
    endtask

    task automatic run_walk();
        send_request(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (levels_owed != 0 || busy);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_node_count(input int v);
        settle();
        cfg_we         <= 1'b1;
        cfg_node_count <= v[CFG_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_graph();
        int cfg_val;
        int n;
        int edge_total;
        int pick;
        int a;
        int b;
        pick = $urandom_range(0, 99);
        if (pick < 65) cfg_val = $urandom_range(2, 12);
        else if (pick < 85) cfg_val = $urandom_range(13, 64);
        else if (pick < 90) cfg_val = 0;
        else cfg_val = $urandom_range(65, 127);
        steady = ($urandom_range(0, 3) == 0);
        write_node_count(cfg_val);
        n = active_of(cfg_val);
        edge_total = (n > 16) ? $urandom_range(0, 24) : $urandom_range(0, 16);
        repeat (edge_total) begin
            pick = $urandom_range(0, 99);
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            if (pick < 8) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
            else if (pick < 85) add_edge(a < b ? a : b, a < b ? b : a);
            else add_edge(a, b);
        end
        if ($urandom_range(0, 9) == 0) write_node_count($urandom_range(1, n));
        run_walk();
    endtask

    task automatic chain_graph();
        int order [64];
        int link [63];
        int j;
        int tmp;
        steady = 1'b0;
        for (int i = 0; i < 64; i++) order[i] = i;
        for (int i = 0; i < 63; i++) link[i] = i;
        for (int i = 63; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        for (int i = 62; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = link[i]; link[i] = link[j]; link[j] = tmp;
        end
        write_node_count(64);
        for (int i = 0; i < 63; i++) add_edge(order[link[i]], order[link[i] + 1]);
        run_walk();
        chains_done++;
    endtask

    task automatic flood_graph();
        int a;
        steady = 1'b0;
        write_node_count(4);
        repeat (MAX_EDGES_DEF) begin
            a = $urandom_range(0, 2);
            add_edge(a, $urandom_range(a + 1, 3));
        end
        // closes a cycle only if the full store failed to drop it
        repeat (14) add_edge(3, 0);
        run_walk();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_node_count = '0;
        start          = 1'b0;
        opcode         = OP_ADD;
        edge_source    = '0;
        edge_target    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_walk();
        write_node_count(1);
        add_edge(0, 0);
        add_edge(0, 1);
        run_walk();
        write_node_count(0);
        run_walk();
        write_node_count(5);
        add_edge(0, 1);
        add_edge(1, 2);
        add_edge(0, 2);
        add_edge(2, 3);
        add_edge(0, 1);
        add_edge(4, 4);
        add_edge(3, 63);
        add_edge(63, 0);
        run_walk();
        write_node_count(6);
        add_edge(0, 5);
        add_edge(5, 1);
        add_edge(1, 2);
        write_node_count(3);
        run_walk();
        write_node_count(127);
        add_edge(63, 62);
        add_edge(42, 21);
        add_edge(21, 63);
        run_walk();
        write_node_count(3);
        add_edge(0, 1);
        add_edge(1, 2);
        add_edge(2, 0);
        run_walk();

        flood_graph();
        while (requests_sent < 480) begin
            if (chains_done < 2 && $urandom_range(0, 11) == 0) chain_graph();
            else random_graph();
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
